// ===== sv/lcrc_pkg.sv =====
// Shared types, constants and the per-byte check update for the telegram checksum.
// No dependencies.
package lcrc_pkg;

    localparam int unsigned CHECK_W = 16;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [CHECK_W-1:0] POLY_RESET     = 16'h8005;
    localparam logic [CHECK_W-1:0] CHECK_TOP_BIT  = 16'h8000;
    localparam logic [CHECK_W-1:0] CHECK_LOW_MASK = 16'h7fff;

    typedef struct packed {
        logic               valid;
        logic [CHECK_W-1:0] value;
    } lcrc_result_t;

    function automatic logic [CHECK_W-1:0] check_advance(
        input logic [CHECK_W-1:0] check,
        input logic [BYTE_W-1:0]  cur,
        input logic [BYTE_W-1:0]  prev,
        input logic [CHECK_W-1:0] poly
    );
        logic [CHECK_W-1:0] shifted;
        shifted = (check & CHECK_LOW_MASK) << 1;
        if ((check & CHECK_TOP_BIT) != '0)
        begin
            shifted = shifted ^ poly;
        end
        return shifted ^ {prev, cur};
    endfunction

endpackage

// ===== sv/lcrc_core.sv =====
// Running check value, previous byte and polynomial register.
// Depends on lcrc_pkg.
module lcrc_core
    import lcrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHECK_W-1:0] cfg_wr_data,
    input  logic               accept,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    output lcrc_result_t       result
);

    logic [CHECK_W-1:0] poly_reg;
    logic [CHECK_W-1:0] check_reg;
    logic [CHECK_W-1:0] check_next;
    logic [BYTE_W-1:0]  prev_reg;
    logic [CHECK_W-1:0] check_base;
    logic [BYTE_W-1:0]  prev_base;

    always_comb
    begin
        check_base = first_byte ? '0 : check_reg;
        prev_base  = first_byte ? '0 : prev_reg;
        check_next = check_advance(check_base, data_byte, prev_base, poly_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg  <= POLY_RESET;
            check_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                poly_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                check_reg <= check_next;
                prev_reg  <= data_byte;
            end
        end
    end

    assign result.valid = accept && last_byte;
    assign result.value = check_next;

    a_prev_tracks_byte: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(data_byte))
        else $error("previous byte not updated on item");

    a_idle_holds_check: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(check_reg) && $stable(prev_reg))
        else $error("check state moved without an item");

    a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> accept && last_byte)
        else $error("result raised without last item");

endmodule

// ===== sv/lcrc_out_reg.sv =====
// Output holding register for check values, with ready feedback to the input side.
// Depends on lcrc_pkg.
module lcrc_out_reg
    import lcrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lcrc_result_t       push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHECK_W-1:0] check_value
);

    logic               valid_reg;
    logic               valid_next;
    logic [CHECK_W-1:0] value_reg;

    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (push.valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            value_reg <= push.value;
        end
    end

    assign out_valid   = valid_reg;
    assign check_value = value_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> room)
        else $error("result pushed over a pending item");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> valid_reg && value_reg == $past(push.value))
        else $error("pushed result not presented");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !push.valid |=> !valid_reg)
        else $error("taken item not dropped");

endmodule

// ===== sv/lidar_crc16_stream.sv =====
// Streaming 16-bit telegram checksum, one byte per item.
// Check value is registered: valid in the cycle after the item marked last is accepted.
// Throughput: one item per cycle while the output register holds no pending result, or the
// pending result is taken in the same cycle; otherwise in_ready drops and input stalls.
// Reset: check value and previous byte clear to zero, polynomial to 0x8005.
// Depends on lcrc_pkg, lcrc_core, lcrc_out_reg.
module lidar_crc16_stream
    import lcrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHECK_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHECK_W-1:0] check_value
);

    logic         room;
    logic         accept;
    lcrc_result_t result;

    assign in_ready = room;
    assign accept   = in_valid && room;

    lcrc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .result      (result)
    );

    lcrc_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (result),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .check_value (check_value)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lidar_crc16_stream: sends telegram bytes with random
// pacing and receiver stalls, predicts every check value and compares each result.
// Depends on lcrc_pkg and the lidar_crc16_stream RTL.
module tb;
    import lcrc_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_TICKS = 4;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned PHASES       = 6;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CHECK_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  data_byte   = '0;
    logic               first_byte  = 1'b0;
    logic               last_byte   = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [CHECK_W-1:0] check_value;

    logic [CHECK_W-1:0] poly_model;
    logic [CHECK_W-1:0] crc_model;
    logic [BYTE_W-1:0]  prev_model;
    logic [CHECK_W-1:0] pending_checks[$];
    logic [CHECK_W-1:0] want_check;

    int unsigned bytes_sent;
    int unsigned telegrams_sent;
    int unsigned checks_seen;
    int unsigned poly_writes;
    int unsigned error_count;
    int unsigned burst_left;
    bit          gaps_on;

    rx_mode_t    rx_mode  = RX_OPEN;
    int unsigned rx_ticks = 0;

    always #5 clk = ~clk;

    lidar_crc16_stream u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .check_value (check_value)
    );

    function automatic logic [CHECK_W-1:0] crc_fold(
        input logic [CHECK_W-1:0] crc,
        input logic [BYTE_W-1:0]  cur,
        input logic [BYTE_W-1:0]  prev,
        input logic [CHECK_W-1:0] poly
    );
        logic [CHECK_W-1:0] nxt;
        nxt = {crc[CHECK_W-2:0], 1'b0};
        if (crc[CHECK_W-1])
        begin
            nxt = nxt ^ poly;
        end
        return nxt ^ {prev, cur};
    endfunction

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l);
        if (f)
        begin
            crc_model  = '0;
            prev_model = '0;
        end
        crc_model  = crc_fold(crc_model, b, prev_model, poly_model);
        prev_model = b;
        if (l)
        begin
            pending_checks.push_back(crc_model);
            telegrams_sent++;
        end
    endtask

    task automatic hold_off(input int unsigned cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l);
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= f;
        last_byte  <= l;
        do @(posedge clk); while (!in_ready);
        predict_byte(b, f, l);
        bytes_sent++;
        if (gaps_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                hold_off($urandom_range(1, 8));
                burst_left = $urandom_range(0, 30);
            end
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (pending_checks.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_poly(input logic [CHECK_W-1:0] p);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        poly_model = p;
        poly_writes++;
    endtask

    task automatic send_telegram(input int unsigned len, input logic [BYTE_W-1:0] fill,
                                 input bit fixed_fill);
        for (int unsigned i = 0; i < len; i++)
        begin
            send_byte(fixed_fill ? fill : BYTE_W'($urandom()), i == 0, i == len - 1);
        end
    endtask

    task automatic test_after_reset();
        send_byte(8'hA5, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b1);
        send_telegram(6, 8'hFF, 1'b1);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b0);
        send_byte(8'h78, 1'b0, 1'b1);
    endtask

    task automatic test_poly_extremes();
        drain_results();
        write_poly(16'h0000);
        send_telegram(3, 8'hFF, 1'b1);
        drain_results();
        write_poly(16'hFFFF);
        send_telegram(3, 8'hFF, 1'b1);
    endtask

    task automatic test_random_telegrams();
        logic [CHECK_W-1:0] poly_set[PHASES];
        int unsigned        target;
        int unsigned        pause_at;
        int unsigned        len;
        int unsigned        pick;
        bit                 paused;
        poly_set = '{POLY_RESET, 16'h0000, 16'hFFFF, CHECK_W'($urandom()),
                     16'h8000, CHECK_W'($urandom())};
        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_poly(poly_set[ph]);
            gaps_on    = (ph != 0);
            burst_left = 0;
            target     = bytes_sent + RANDOM_ITEMS / PHASES;
            pause_at   = bytes_sent + $urandom_range(20, RANDOM_ITEMS / PHASES - 20);
            paused     = 1'b0;
            while (bytes_sent < target)
            begin
                if (!paused && bytes_sent >= pause_at)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    // drop framing: stray flags, missing starts, restarts mid-telegram
                    repeat ($urandom_range(1, 10))
                    begin
                        send_byte(BYTE_W'($urandom()), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 5) == 0);
                    end
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                    begin
                        len = $urandom_range(1, 8);
                    end
                    else if (pick < 95)
                    begin
                        len = $urandom_range(9, 24);
                    end
                    else
                    begin
                        len = $urandom_range(25, 64);
                    end
                    send_telegram(len, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                  $urandom_range(0, 19) == 0);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_ticks == 0)
        begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_ticks <= $urandom_range(16, 80);
        end
        else
        begin
            rx_ticks <= rx_ticks - 1;
        end
        unique case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= $urandom_range(0, 1);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            RX_BEAT:   out_ready <= (rx_ticks % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            checks_seen++;
            if (pending_checks.size() == 0)
            begin
                $display("%0t: unexpected check_value, expected none, actual %04h",
                         $time, check_value);
                error_count++;
            end
            else
            begin
                want_check = pending_checks.pop_front();
                if (check_value !== want_check)
                begin
                    $display("%0t: check_value mismatch, expected %04h, actual %04h",
                             $time, want_check, check_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_checks.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        poly_model     = POLY_RESET;
        crc_model      = '0;
        prev_model     = '0;
        bytes_sent     = 0;
        telegrams_sent = 0;
        checks_seen    = 0;
        poly_writes    = 0;
        error_count    = 0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_field_extremes();
        test_poly_extremes();
        test_random_telegrams();
        drain_results();

        $display("run covered %0d bytes, %0d telegrams, %0d check values compared",
                 bytes_sent, telegrams_sent, checks_seen);
        $display("under %0d polynomial writes plus the reset polynomial, %0d mismatches",
                 poly_writes, error_count);
        if (error_count == 0 && pending_checks.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
